/* hw/rtl/cmux_basic_frame_deframer_defines.svh */
// Assertion helpers for the deframer.
`ifndef CMUX_BASIC_FRAME_DEFRAMER_DEFINES_SVH
`define CMUX_BASIC_FRAME_DEFRAMER_DEFINES_SVH

// Implication property, checked on every clock edge outside reset.
`define CBFD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CBFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cbfd_pkg.sv */
package cbfd_pkg;

   // Reset value of the flag register
   localparam logic [7:0] FLAG_RESET = 8'hF9;
   // Channel number sits in the top six bits of the address byte
   localparam int unsigned CHAN_LSB = 2;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_ADDR  = 3'd1,
      PH_CTRL  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_FCS   = 3'd5,
      PH_CLOSE = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

endpackage

/* hw/rtl/cmux_basic_frame_deframer.sv */
// Basic-option multiplexer frame deframer. Received bytes enter on the req_
// channel, one per transaction, and the phase machine steps once per byte: the
// block sustains one byte per clock cycle unless rsp_stall holds back a result;
// a result reaches rsp_ through the input register, then the result register.
// Only payload bytes, the frame-done marker and the framing-error marker produce
// a result; flag hunting, header and FCS bytes are consumed silently. The FCS is
// not checked. The flag value is set through csr_, which is always ready and
// must be written only while the block is idle.
`include "cmux_basic_frame_deframer_defines.svh"

module cmux_basic_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   // receive byte channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_payload,
   output logic [5:0] rsp_channel,
   output logic [7:0] rsp_control,
   output logic [6:0] rsp_frame_len,
   // flag register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_flag_byte
);

   cbfd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] flag_ff, flag_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [5:0] chan_ff, chan_in;
   logic [7:0] ctrl_ff, ctrl_in;
   logic [6:0] len_ff, len_in;
   logic [6:0] left_ff, left_in;
   logic       out_valid_ff, out_valid_in;
   cbfd_pkg::kind_type out_kind_ff, out_kind_in;
   logic [7:0] out_payload_ff, out_payload_in;
   logic [5:0] out_chan_ff, out_chan_in;
   logic [7:0] out_ctrl_ff, out_ctrl_in;
   logic [6:0] out_len_ff, out_len_in;

   logic               produce;
   cbfd_pkg::kind_type emit_kind;
   logic [7:0]         emit_payload;
   logic               out_free;
   logic               in_move;

   // Handshake control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && (!produce || out_free);
   assign req_stall = in_valid_ff && !in_move;
   assign csr_ready = 1'b1;

   // Flag register
   always_comb begin
      flag_in = flag_ff;
      if (csr_valid) begin
         flag_in = csr_flag_byte;
      end
   end

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff && !in_move;
      in_byte_in  = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_move) begin
         unique case (phase_ff)
            cbfd_pkg::PH_ADDR: phase_in = cbfd_pkg::PH_CTRL;
            cbfd_pkg::PH_CTRL: phase_in = cbfd_pkg::PH_LEN;
            cbfd_pkg::PH_LEN: begin
               phase_in = (in_byte_ff[7:1] == 7'd0) ? cbfd_pkg::PH_FCS
                                                    : cbfd_pkg::PH_DATA;
            end
            cbfd_pkg::PH_DATA: begin
               if (left_ff == 7'd1) begin
                  phase_in = cbfd_pkg::PH_FCS;
               end
            end
            cbfd_pkg::PH_FCS:   phase_in = cbfd_pkg::PH_CLOSE;
            cbfd_pkg::PH_CLOSE: phase_in = cbfd_pkg::PH_HUNT;
            default: begin
               // hunting, and the unused code
               phase_in = (in_byte_ff == flag_ff) ? cbfd_pkg::PH_ADDR
                                                  : cbfd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // Phase outputs: header capture and result generation
   always_comb begin
      produce      = 1'b0;
      emit_kind    = cbfd_pkg::KIND_DATA;
      emit_payload = 8'd0;
      chan_in      = chan_ff;
      ctrl_in      = ctrl_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      unique case (phase_ff)
         cbfd_pkg::PH_ADDR: begin
            if (in_move) begin
               chan_in = in_byte_ff[7:cbfd_pkg::CHAN_LSB];
            end
         end
         cbfd_pkg::PH_CTRL: begin
            if (in_move) begin
               ctrl_in = in_byte_ff;
            end
         end
         cbfd_pkg::PH_LEN: begin
            if (in_move) begin
               len_in  = in_byte_ff[7:1];
               left_in = in_byte_ff[7:1];
            end
         end
         cbfd_pkg::PH_DATA: begin
            produce      = in_valid_ff;
            emit_payload = in_byte_ff;
            if (in_move) begin
               left_in = left_ff - 7'd1;
            end
         end
         cbfd_pkg::PH_CLOSE: begin
            produce   = in_valid_ff;
            emit_kind = (in_byte_ff == flag_ff) ? cbfd_pkg::KIND_DONE
                                                : cbfd_pkg::KIND_ERR;
         end
         default: begin
         end
      endcase
   end

   // Result register
   always_comb begin
      out_valid_in   = out_valid_ff && rsp_stall;
      out_kind_in    = out_kind_ff;
      out_payload_in = out_payload_ff;
      out_chan_in    = out_chan_ff;
      out_ctrl_in    = out_ctrl_ff;
      out_len_in     = out_len_ff;
      if (in_move && produce) begin
         out_valid_in   = 1'b1;
         out_kind_in    = emit_kind;
         out_payload_in = emit_payload;
         out_chan_in    = chan_ff;
         out_ctrl_in    = ctrl_ff;
         out_len_in     = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cbfd_pkg::PH_HUNT;
         flag_ff      <= cbfd_pkg::FLAG_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         chan_ff      <= 6'd0;
         ctrl_ff      <= 8'd0;
         len_ff       <= 7'd0;
         left_ff      <= 7'd0;
      end else begin
         phase_ff     <= phase_in;
         flag_ff      <= flag_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         chan_ff      <= chan_in;
         ctrl_ff      <= ctrl_in;
         len_ff       <= len_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      out_kind_ff    <= out_kind_in;
      out_payload_ff <= out_payload_in;
      out_chan_ff    <= out_chan_in;
      out_ctrl_ff    <= out_ctrl_in;
      out_len_ff     <= out_len_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_payload   = out_payload_ff;
   assign rsp_channel   = out_chan_ff;
   assign rsp_control   = out_ctrl_ff;
   assign rsp_frame_len = out_len_ff;

   // Checks
   `CBFD_ASSERT_IMPL(a_stall_only_when_blocked, req_stall, in_valid_ff && out_valid_ff && rsp_stall, "input stalled without a blocked result")
   `CBFD_ASSERT_IMPL(a_data_count_nonzero, phase_ff == cbfd_pkg::PH_DATA, left_ff != 7'd0, "payload phase with no bytes left")
   `CBFD_ASSERT_NEXT(a_close_emits, in_move && phase_ff == cbfd_pkg::PH_CLOSE, out_valid_ff && phase_ff == cbfd_pkg::PH_HUNT && out_payload_ff == 8'd0, "closing byte did not end the frame")
   `CBFD_ASSERT_NEXT(a_zero_len_skips, in_move && phase_ff == cbfd_pkg::PH_LEN && in_byte_ff[7:1] == 7'd0, phase_ff == cbfd_pkg::PH_FCS, "zero length frame entered payload phase")

endmodule

/* tb/cmux_basic_frame_deframer_checker.sv */
// Watches the byte, result and flag-register channels of the deframer.
// Keeps its own copy of the frame phase machine and checks every result
// transaction against the oldest outstanding prediction.
module cmux_basic_frame_deframer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_payload,
   input  logic [5:0]  rsp_channel,
   input  logic [7:0]  rsp_control,
   input  logic [6:0]  rsp_frame_len,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_flag_byte,
   input  logic        end_of_run,
   output int unsigned fail_count,
   output int unsigned pending
);

   typedef struct packed {
      cbfd_pkg::kind_type kind;
      logic [7:0] payload;
      logic [5:0] channel;
      logic [7:0] control;
      logic [6:0] frame_len;
   } frame_event_type;

   frame_event_type events_due[$];

   // Shadow of the deframer state and flag register
   cbfd_pkg::phase_type phase = cbfd_pkg::PH_HUNT;
   logic [7:0]  flag_value = cbfd_pkg::FLAG_RESET;
   logic [5:0]  chan       = '0;
   logic [7:0]  ctrl       = '0;
   logic [6:0]  flen       = '0;
   logic [6:0]  left       = '0;
   int unsigned errors     = 0;
   bit          leftovers_checked = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Step the predicted phase machine by one received byte
   task automatic deframe_byte(input logic [7:0] b);
      frame_event_type ev;
      ev.kind      = cbfd_pkg::KIND_DATA;
      ev.payload   = 8'd0;
      ev.channel   = chan;
      ev.control   = ctrl;
      ev.frame_len = flen;
      case (phase)
         cbfd_pkg::PH_ADDR: begin
            chan  = 6'(b >> cbfd_pkg::CHAN_LSB);
            phase = cbfd_pkg::PH_CTRL;
         end
         cbfd_pkg::PH_CTRL: begin
            ctrl  = b;
            phase = cbfd_pkg::PH_LEN;
         end
         cbfd_pkg::PH_LEN: begin
            // bit 0 (extension bit) is ignored
            flen = b[7:1];
            left = b[7:1];
            if (b[7:1] == 7'd0) begin
               phase = cbfd_pkg::PH_FCS;
            end else begin
               phase = cbfd_pkg::PH_DATA;
            end
         end
         cbfd_pkg::PH_DATA: begin
            ev.payload = b;
            events_due.push_back(ev);
            left = left - 7'd1;
            if (left == 7'd0) begin
               phase = cbfd_pkg::PH_FCS;
            end
         end
         cbfd_pkg::PH_FCS: begin
            // FCS is skipped unchecked
            phase = cbfd_pkg::PH_CLOSE;
         end
         cbfd_pkg::PH_CLOSE: begin
            if (b == flag_value) begin
               ev.kind = cbfd_pkg::KIND_DONE;
            end else begin
               ev.kind = cbfd_pkg::KIND_ERR;
            end
            events_due.push_back(ev);
            phase = cbfd_pkg::PH_HUNT;
         end
         default: begin
            if (b == flag_value) begin
               phase = cbfd_pkg::PH_ADDR;
            end else begin
               phase = cbfd_pkg::PH_HUNT;
            end
         end
      endcase
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch_edge
      frame_event_type want;
      if (reset) begin
         events_due.delete();
         phase      = cbfd_pkg::PH_HUNT;
         flag_value = cbfd_pkg::FLAG_RESET;
         chan       = '0;
         ctrl       = '0;
         flen       = '0;
         left       = '0;
      end else begin
         // results first, so a byte taken at this edge cannot match itself
         if (rsp_valid && !rsp_stall) begin
            if (events_due.size() == 0) begin
               $error("unexpected result transaction: kind %0d payload %0d channel %0d",
                      rsp_kind, rsp_payload, rsp_channel);
               errors++;
            end else begin
               want = events_due.pop_front();
               compare_field("kind", want.kind, rsp_kind);
               compare_field("payload", want.payload, rsp_payload);
               compare_field("channel", want.channel, rsp_channel);
               compare_field("control", want.control, rsp_control);
               compare_field("frame_len", want.frame_len, rsp_frame_len);
            end
         end
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
         end
         // new flag applies from the next byte on
         if (csr_valid && csr_ready) begin
            flag_value = csr_flag_byte;
         end
         if (end_of_run && !leftovers_checked) begin
            leftovers_checked = 1;
            if (events_due.size() != 0) begin
               $error("%0d expected results never arrived", events_due.size());
               errors++;
            end
         end
      end
      fail_count <= errors;
      pending    <= events_due.size();
   end

endmodule

/* tb/cmux_basic_frame_deframer_test.sv */
// Stimulus and verdict for the deframer: directed frames, then random
// well-formed frames mixed with noise and broken frames, under three idle
// profiles and several flag values.
module cmux_basic_frame_deframer_test;

   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned BYTES_PER_STEP = 270;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_payload;
   logic [5:0] rsp_channel;
   logic [7:0] rsp_control;
   logic [6:0] rsp_frame_len;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_flag_byte = 8'd0;
   logic       end_of_run = 1'b0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned sender_idle   = 35;
   int unsigned receiver_idle = 83;
   bit          hold_request  = 0;
   logic [7:0]  flag_value    = cbfd_pkg::FLAG_RESET;
   int unsigned framed_bytes  = 0;
   int unsigned frames_sent   = 0;
   int unsigned flags_used    = 1;
   int unsigned idle_cycles   = 0;

   cmux_basic_frame_deframer i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_payload   (rsp_payload),
      .rsp_channel   (rsp_channel),
      .rsp_control   (rsp_control),
      .rsp_frame_len (rsp_frame_len),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_flag_byte (csr_flag_byte)
   );

   cmux_basic_frame_deframer_checker i_frame_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_payload   (rsp_payload),
      .rsp_channel   (rsp_channel),
      .rsp_control   (rsp_control),
      .rsp_frame_len (rsp_frame_len),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_flag_byte (csr_flag_byte),
      .end_of_run    (end_of_run),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: random stalls, or one long hold-off when requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 0;
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle);
      end
   end

   // Watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One byte transaction, with random idle cycles in front of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [7:0] non_flag_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == flag_value);
      return b;
   endfunction

   // Complete frame with random header and payload; flag value may appear as data
   task automatic send_frame(input int unsigned plen, input bit close_good);
      send_byte(flag_value);
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
      send_byte({7'(plen), 1'($urandom_range(1))});
      repeat (plen) begin
         if ($urandom_range(15) == 0) begin
            send_byte(flag_value);
         end else begin
            send_byte(8'($urandom_range(255)));
         end
      end
      send_byte(8'($urandom_range(255)));
      if (close_good) begin
         send_byte(flag_value);
      end else begin
         send_byte(non_flag_byte());
      end
      framed_bytes += plen + 6;
      frames_sent++;
   endtask

   // Stop offering and wait until every predicted result has been taken
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_flag(input logic [7:0] v);
      drain();
      csr_valid     <= 1'b1;
      csr_flag_byte <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      flag_value = v;
      flags_used++;
   endtask

   // Mostly well-formed frames; some noise, bad closes and cut-short frames
   task automatic random_traffic(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = framed_bytes + count;
      while (framed_bytes < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            send_frame($urandom_range(12), $urandom_range(9) != 0);
         end else if (pick < 80) begin
            send_frame(127, 1);
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 6)) send_byte(non_flag_byte());
         end else begin
            // header cut short; following bytes get absorbed into this frame
            send_byte(flag_value);
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      logic [7:0] opening [21];
      opening = '{8'h00, 8'hFF,
                  8'hF9, 8'hFF, 8'h00, 8'h05, 8'hF9, 8'h00, 8'hAA, 8'hF9,
                  8'hF9, 8'h00, 8'hFF, 8'h00, 8'h55, 8'h00,
                  8'hF9, 8'hF9, 8'hF9, 8'h03, 8'h7F};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // sender light, receiver heavy
      sender_idle   = 35;
      receiver_idle = 83;
      foreach (opening[i]) send_byte(opening[i]);
      // closing transactions of the header-full-of-flags frame
      send_byte(8'hF9);
      send_byte(8'hF9);
      random_traffic(BYTES_PER_STEP - 23);
      write_flag(8'h00);
      random_traffic(BYTES_PER_STEP);

      // sender heavy, receiver light
      sender_idle   = 83;
      receiver_idle = 35;
      write_flag(8'hFF);
      random_traffic(BYTES_PER_STEP);
      write_flag(8'h7E);
      random_traffic(BYTES_PER_STEP);

      // no idling; long hold-off on results while a long frame goes in
      sender_idle   = 0;
      receiver_idle = 0;
      write_flag(8'($urandom_range(255)));
      hold_request = 1;
      send_frame(127, 1);
      random_traffic(BYTES_PER_STEP / 2);
      drain();
      random_traffic(BYTES_PER_STEP / 2);
      write_flag(cbfd_pkg::FLAG_RESET);
      random_traffic(BYTES_PER_STEP);

      drain();
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Covered %0d framed bytes in %0d frames with %0d flag values,",
               framed_bytes, frames_sent, flags_used);
      $display("three idle profiles, noise, bad closes and a long result hold-off.");
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
